/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Needs only a clock and an active-high reset at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in the same cycle implies consequent
`define PMU_ASSERT_SAME(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PMU_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

// checked also while reset is high
`define PMU_ASSERT_ALWAYS_NEXT(label, clk, a, c) \
   label: assert property (@(posedge clk) (a) |=> (c)) \
      else $error("assertion failed");

`endif

/* rtl/pmu_pkg.sv */
// Types, constants and helper functions for the particle motion update block.
// No dependencies.
package pmu_pkg;

   localparam int FORCE_COUNT = 3;
   localparam int QUOT_BITS   = 16;
   localparam int DIV_STEPS   = 2;                       // quotient bits per stage
   localparam int DIV_STAGES  = QUOT_BITS / DIV_STEPS;
   localparam int MOTION_DLY  = DIV_STAGES - 2;          // aligns motion with quotient
   localparam int PIPE_DEPTH  = DIV_STAGES + 3;

   localparam logic [1:0] CSR_TIME_STEP    = 2'd0;
   localparam logic [1:0] CSR_DRAG_FACTOR  = 2'd1;
   localparam logic [1:0] CSR_GRAVITY_STEP = 2'd2;
   localparam logic [1:0] CSR_FLOOR_HEIGHT = 2'd3;

   localparam logic [31:0] RST_TIME_STEP    = 32'd1092;
   localparam logic [16:0] RST_DRAG_FACTOR  = 17'd65536;
   localparam logic [30:0] RST_GRAVITY_STEP = 31'd1638;
   localparam logic [31:0] RST_FLOOR_HEIGHT = 32'hFFFA_999A;   // -5.4

   localparam logic [16:0] RATIO_ONE  = 17'd65536;
   localparam logic [16:0] BAND_HIGH  = 17'd49152;
   localparam logic [16:0] BAND_LOW   = 17'd16384;

   typedef enum logic [1:0] {
      RATIO_ZERO,
      RATIO_FULL,
      RATIO_DIV
   } ratio_mode_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic        [31:0] life_left;
      logic        [31:0] life_full;
      logic        [2:0]  force_enables;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic        [31:0] new_life_left;
      logic               alive;
      logic        [7:0]  red;
      logic        [7:0]  green;
      logic        [7:0]  blue;
   } rsp_type;

   typedef struct packed {
      rsp_type        rsp;
      ratio_mode_type mode;
   } mid_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sh0_7FFF_FFFF)
         return 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000)
         return 32'sh8000_0000;
      else
         return v[31:0];
   endfunction

   // round half up, then saturate
   function automatic logic signed [31:0] drag_round(input logic signed [49:0] p);
      logic signed [49:0] r;
      r = p + 50'sd32768;
      return sat32(r[49:16]);
   endfunction

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [32:0] div_step(input logic [31:0] rem,
                                            input logic [31:0] dv);
      logic [32:0] sh;
      logic [32:0] df;
      sh = {rem, 1'b0};
      df = sh - {1'b0, dv};
      if (sh >= {1'b0, dv})
         return {1'b1, df[31:0]};
      else
         return {1'b0, sh[31:0]};
   endfunction

   // Q1.16 channel to 8 bits, rounded
   function automatic logic [7:0] to8(input logic [16:0] c);
      logic [24:0] m;
      m = {c, 8'd0} - {8'd0, c} + 25'd32768;
      return m[23:16];
   endfunction

endpackage

/* rtl/pmu_div.sv */
// Pipelined restoring divider for the lifetime ratio, two quotient bits per stage.
// Depends on pmu_pkg.
module pmu_div (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic [pmu_pkg::QUOT_BITS-1:0] quotient
);

   logic [31:0]                   rem_ff [pmu_pkg::DIV_STAGES];
   logic [31:0]                   dv_ff  [pmu_pkg::DIV_STAGES];
   logic [pmu_pkg::QUOT_BITS-1:0] q_ff   [pmu_pkg::DIV_STAGES];

   for (genvar k = 0; k < pmu_pkg::DIV_STAGES; k++) begin : g_stage
      logic [31:0]                   rem_src;
      logic [31:0]                   dv_src;
      logic [pmu_pkg::QUOT_BITS-1:0] q_src;
      logic [32:0]                   st [pmu_pkg::DIV_STEPS+1];
      logic [pmu_pkg::QUOT_BITS-1:0] q_in;

      if (k == 0) begin : g_first
         assign rem_src = dividend;
         assign dv_src  = divisor;
         assign q_src   = '0;
      end else begin : g_rest
         assign rem_src = rem_ff[k-1];
         assign dv_src  = dv_ff[k-1];
         assign q_src   = q_ff[k-1];
      end

      always_comb begin
         st[0] = {1'b0, rem_src};
         q_in  = q_src;
         for (int s = 0; s < pmu_pkg::DIV_STEPS; s++) begin
            st[s+1] = pmu_pkg::div_step(st[s][31:0], dv_src);
            q_in    = {q_in[pmu_pkg::QUOT_BITS-2:0], st[s+1][32]};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= st[pmu_pkg::DIV_STEPS][31:0];
            dv_ff[k]  <= dv_src;
            q_ff[k]   <= q_in;
         end
      end
   end

   assign quotient = q_ff[pmu_pkg::DIV_STAGES-1];

endmodule

/* rtl/particle_motion_update.sv */
// Particle motion update: top level with force, position, lifetime and colour stages.
// Depends on pmu_pkg and pmu_div.

// Fully pipelined: one particle transfer per cycle unless the result side stalls; one
// stage for drag products and lifetime decrement, eight stages of the lifetime-ratio
// divider at two quotient bits each, two colour stages. A stall on the result side
// holds the whole pipeline; req_stall is high exactly while a result waits under stall.
module particle_motion_update (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pmu_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pmu_pkg::rsp_type    rsp_data,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);

   typedef struct packed {
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic signed [31:0] vel_x, vel_y, vel_z;
      logic signed [49:0] prod_x, prod_y, prod_z;
      logic        [31:0] life_new;
      logic        [31:0] life_full;
      logic        [2:0]  forces;
      logic               below;
   } s1_type;

   typedef struct packed {
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic signed [31:0] vel_x, vel_y, vel_z;
      logic        [31:0] life_new;
      logic               alive;
      pmu_pkg::ratio_mode_type mode;
   } s2_type;

   logic [31:0] time_step_ff;
   logic [16:0] drag_factor_ff;
   logic [30:0] gravity_step_ff;
   logic signed [31:0] floor_height_ff;

   logic [pmu_pkg::PIPE_DEPTH-1:0] valid_ff;
   logic                           enable;

   s1_type           s1_ff, s1_in;
   s2_type           s2_ff, s2_in;
   pmu_pkg::mid_type s3_ff, s3_in;
   pmu_pkg::mid_type dly_ff [pmu_pkg::MOTION_DLY];

   logic [pmu_pkg::QUOT_BITS-1:0] quot;

   pmu_pkg::rsp_type c1_rec_ff;
   logic [16:0]      c1_ratio_ff, c1_ratio_in;
   logic [33:0]      c1_prod_ff, c1_prod_in;
   logic             c1_hi_ff, c1_hi_in, c1_mid_ff, c1_mid_in;
   pmu_pkg::rsp_type out_ff, out_in;

   assign enable    = !(valid_ff[pmu_pkg::PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !enable;
   assign rsp_valid = valid_ff[pmu_pkg::PIPE_DEPTH-1];
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff    <= pmu_pkg::RST_TIME_STEP;
         drag_factor_ff  <= pmu_pkg::RST_DRAG_FACTOR;
         gravity_step_ff <= pmu_pkg::RST_GRAVITY_STEP;
         floor_height_ff <= pmu_pkg::RST_FLOOR_HEIGHT;
      end else if (csr_write) begin
         case (csr_index)
            pmu_pkg::CSR_TIME_STEP:    time_step_ff    <= csr_data;
            pmu_pkg::CSR_DRAG_FACTOR:  drag_factor_ff  <= csr_data[16:0];
            pmu_pkg::CSR_GRAVITY_STEP: gravity_step_ff <= csr_data[30:0];
            pmu_pkg::CSR_FLOOR_HEIGHT: floor_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[pmu_pkg::PIPE_DEPTH-2:0], req_valid};
      end
   end

   // stage 1: drag products, lifetime decrement, floor compare
   always_comb begin
      logic signed [17:0] df;
      df = $signed({1'b0, drag_factor_ff});
      s1_in.pos_x     = req_data.pos_x;
      s1_in.pos_y     = req_data.pos_y;
      s1_in.pos_z     = req_data.pos_z;
      s1_in.vel_x     = req_data.vel_x;
      s1_in.vel_y     = req_data.vel_y;
      s1_in.vel_z     = req_data.vel_z;
      s1_in.prod_x    = req_data.vel_x * df;
      s1_in.prod_y    = req_data.vel_y * df;
      s1_in.prod_z    = req_data.vel_z * df;
      s1_in.life_new  = (req_data.life_left >= time_step_ff)
                        ? req_data.life_left - time_step_ff : 32'd0;
      s1_in.life_full = req_data.life_full;
      s1_in.forces    = req_data.force_enables;
      s1_in.below     = req_data.pos_y <= floor_height_ff;
   end

   // stage 2: forces in bit order, ratio mode
   always_comb begin
      logic signed [31:0] vy1;
      vy1 = s1_ff.forces[0] ? pmu_pkg::drag_round(s1_ff.prod_y) : s1_ff.vel_y;
      if (s1_ff.forces[1])
         vy1 = pmu_pkg::sat32(34'(vy1) - $signed({3'b000, gravity_step_ff}));
      if (s1_ff.forces[2] && s1_ff.below)
         vy1 = pmu_pkg::sat32(-34'(vy1));
      s2_in.pos_x    = s1_ff.pos_x;
      s2_in.pos_y    = s1_ff.pos_y;
      s2_in.pos_z    = s1_ff.pos_z;
      s2_in.vel_x    = s1_ff.forces[0] ? pmu_pkg::drag_round(s1_ff.prod_x) : s1_ff.vel_x;
      s2_in.vel_y    = vy1;
      s2_in.vel_z    = s1_ff.forces[0] ? pmu_pkg::drag_round(s1_ff.prod_z) : s1_ff.vel_z;
      s2_in.life_new = s1_ff.life_new;
      s2_in.alive    = (s1_ff.life_full != 32'd0) && (s1_ff.life_new != 32'd0);
      if (s1_ff.life_full == 32'd0)
         s2_in.mode = pmu_pkg::RATIO_ZERO;
      else if (s1_ff.life_new >= s1_ff.life_full)
         s2_in.mode = pmu_pkg::RATIO_FULL;
      else
         s2_in.mode = pmu_pkg::RATIO_DIV;
   end

   // stage 3: position update
   always_comb begin
      s3_in.rsp.new_pos_x     = s2_ff.pos_x + s2_ff.vel_x;
      s3_in.rsp.new_pos_y     = s2_ff.pos_y + s2_ff.vel_y;
      s3_in.rsp.new_pos_z     = s2_ff.pos_z + s2_ff.vel_z;
      s3_in.rsp.new_vel_x     = s2_ff.vel_x;
      s3_in.rsp.new_vel_y     = s2_ff.vel_y;
      s3_in.rsp.new_vel_z     = s2_ff.vel_z;
      s3_in.rsp.new_life_left = s2_ff.life_new;
      s3_in.rsp.alive         = s2_ff.alive;
      s3_in.rsp.red           = '0;
      s3_in.rsp.green         = '0;
      s3_in.rsp.blue          = '0;
      s3_in.mode              = s2_ff.mode;
   end

   pmu_div u_div (
      .clock    (clock),
      .enable   (enable),
      .dividend (s1_ff.life_new),
      .divisor  (s1_ff.life_full),
      .quotient (quot)
   );

   // colour stage 1: band select and one multiply
   always_comb begin
      logic [16:0] d;
      case (dly_ff[pmu_pkg::MOTION_DLY-1].mode)
         pmu_pkg::RATIO_ZERO: c1_ratio_in = '0;
         pmu_pkg::RATIO_FULL: c1_ratio_in = pmu_pkg::RATIO_ONE;
         pmu_pkg::RATIO_DIV:  c1_ratio_in = {1'b0, quot};
         default:             c1_ratio_in = '0;
      endcase
      c1_hi_in  = c1_ratio_in > pmu_pkg::BAND_HIGH;
      c1_mid_in = c1_ratio_in > pmu_pkg::BAND_LOW;
      d = c1_ratio_in - (c1_hi_in ? pmu_pkg::BAND_HIGH : pmu_pkg::BAND_LOW);
      c1_prod_in = c1_ratio_in * d;
   end

   // colour stage 2: channels to 8 bits
   always_comb begin
      logic [16:0] g, b;
      if (c1_hi_ff) begin
         g = c1_ratio_ff;
         b = c1_prod_ff[30:14];
      end else if (c1_mid_ff) begin
         g = c1_prod_ff[31:15];
         b = '0;
      end else begin
         g = '0;
         b = '0;
      end
      out_in       = c1_rec_ff;
      out_in.red   = pmu_pkg::to8(c1_ratio_ff);
      out_in.green = pmu_pkg::to8(g);
      out_in.blue  = pmu_pkg::to8(b);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         s3_ff       <= s3_in;
         dly_ff[0]   <= s3_ff;
         for (int k = 1; k < pmu_pkg::MOTION_DLY; k++)
            dly_ff[k] <= dly_ff[k-1];
         c1_rec_ff   <= dly_ff[pmu_pkg::MOTION_DLY-1].rsp;
         c1_ratio_ff <= c1_ratio_in;
         c1_prod_ff  <= c1_prod_in;
         c1_hi_ff    <= c1_hi_in;
         c1_mid_ff   <= c1_mid_in;
         out_ff      <= out_in;
      end
   end

endmodule

/* rtl/pmu_checker.sv */
// Port-level checks for particle_motion_update, bound to the top level.
// Depends on pmu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pmu_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pmu_pkg::rsp_type rsp_data
);

   logic black;

   assign black = (rsp_data.red == 8'd0) && (rsp_data.green == 8'd0) && (rsp_data.blue == 8'd0);

   `PMU_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid)
   `PMU_ASSERT_SAME(a_stall_back, clock, reset, 1'b1, req_stall == (rsp_valid && rsp_stall))
   `PMU_ASSERT_SAME(a_dead_black, clock, reset, rsp_valid && !rsp_data.alive, black)
   `PMU_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind particle_motion_update pmu_checker u_pmu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
